### rtl/core/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character classifier for the decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // queue between the front and the back
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // character codes
    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_DIG_0 = 8'h30;
    localparam logic [7:0] CHAR_DIG_9 = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;

    // sextet values of the alphabet ranges
    localparam logic [5:0] VAL_LO_BASE = 6'd26;
    localparam logic [5:0] VAL_DIG_BASE = 6'd52;
    localparam logic [5:0] VAL_MINUS   = 6'd62;
    localparam logic [5:0] VAL_UNDER   = 6'd63;

    // group positions
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    // one classified character as it travels through the queue
    typedef struct packed {
        logic [5:0] value;   // sextet, zero for pad and invalid characters
        logic       is_pad;
        logic       is_bad;
        logic       last;
    } char_class_t;

    // queue status seen by the front and the back
    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_stat_t;

    // map a raw character to its class
    function automatic char_class_t classify(input logic [7:0] ch, input logic last);
        char_class_t c;
        logic [7:0]  diff;
        c.value  = '0;
        c.is_pad = 1'b0;
        c.is_bad = 1'b0;
        c.last   = last;
        diff     = '0;
        if (ch == CHAR_PAD) begin
            c.is_pad = 1'b1;
        end
        else if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z) begin
            diff    = ch - CHAR_UP_A;
            c.value = diff[5:0];
        end
        else if (ch >= CHAR_LO_A && ch <= CHAR_LO_Z) begin
            diff    = ch - CHAR_LO_A;
            c.value = diff[5:0] + VAL_LO_BASE;
        end
        else if (ch >= CHAR_DIG_0 && ch <= CHAR_DIG_9) begin
            diff    = ch - CHAR_DIG_0;
            c.value = diff[5:0] + VAL_DIG_BASE;
        end
        else if (ch == CHAR_MINUS) begin
            c.value = VAL_MINUS;
        end
        else if (ch == CHAR_UNDER) begin
            c.value = VAL_UNDER;
        end
        else begin
            c.is_bad = 1'b1;
        end
        return c;
    endfunction

endpackage

### rtl/core/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts input transactions and classifies each character for the back.
// ----------------------------------------------------------------------------
module b64d_front
    import b64d_pkg::*;
(
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_char,
    input  logic        in_last,
    input  queue_stat_t q_stat,
    output logic        push,
    output char_class_t push_data
);

    // hold off the sender while the queue has no room
    assign in_stall = q_stat.full;
    assign push     = in_valid & ~q_stat.full;

    // alphabet lookup
    assign push_data = classify(in_char, in_last);

endmodule

### rtl/core/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Small flip-flop queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module b64d_queue
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  char_class_t push_data,
    input  logic        pop,
    output char_class_t pop_data,
    output queue_stat_t q_stat
);

    char_class_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data         = entry_reg[rd_ptr_reg];
    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.full      = (count_reg == CNT_W'(QUEUE_DEPTH));

endmodule

### rtl/core/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Group tracking, byte assembly and the registered output transaction.
// ----------------------------------------------------------------------------
module b64d_back
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_stat_t q_stat,
    input  char_class_t pop_data,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        byte_valid,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        decode_error
);

    logic [1:0] pos_reg, pos_next;
    logic [5:0] prev_reg, prev_next;
    logic       err_reg, err_next;
    logic       valid_reg;
    logic       bv_reg, bv_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg;
    logic       oerr_reg, oerr_next;
    logic [7:0] assembled;

    // take the next character when the output slot is free or being drained
    assign pop = q_stat.not_empty & (~valid_reg | ~out_stall);

    // byte assembly from previous and current sextet
    always_comb
    begin
        unique case (pos_reg)
            POS_SECOND: assembled = {prev_reg, pop_data.value[5:4]};
            POS_THIRD:  assembled = {prev_reg[3:0], pop_data.value[5:2]};
            POS_FOURTH: assembled = {prev_reg[1:0], pop_data.value};
            default:    assembled = '0;
        endcase
    end

    // error, emit and next group state
    always_comb
    begin
        oerr_next = err_reg | pop_data.is_bad
                  | (pop_data.is_pad & ~pos_reg[1])
                  | (pop_data.last & (pos_reg == POS_FIRST));
        bv_next   = ~pop_data.is_pad & ~pop_data.is_bad
                  & (pos_reg != POS_FIRST) & ~oerr_next;
        byte_next = bv_next ? assembled : 8'h00;
        if (pop_data.last)
        begin
            pos_next  = POS_FIRST;
            prev_next = '0;
            err_next  = 1'b0;
        end
        else
        begin
            pos_next  = pos_reg + 1'b1;
            prev_next = pop_data.value;
            err_next  = oerr_next;
        end
    end

    // group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_FIRST;
            prev_reg <= '0;
            err_reg  <= 1'b0;
        end
        else if (pop)
        begin
            pos_reg  <= pos_next;
            prev_reg <= prev_next;
            err_reg  <= err_next;
        end
    end

    // output transaction valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            bv_reg   <= bv_next;
            byte_reg <= byte_next;
            last_reg <= pop_data.last;
            oerr_reg <= oerr_next;
        end
    end

    assign out_valid    = valid_reg;
    assign byte_valid   = bv_reg;
    assign out_byte     = byte_reg;
    assign out_last     = last_reg;
    assign decode_error = oerr_reg;

endmodule

### rtl/core/base64url_decoder_unit.sv
// ----------------------------------------------------------------------------
// base64url_decoder_unit
// Base64url character stream to byte stream decoder.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one character per transaction,
//   in_last marks the final character of a segment.
//   Output channel (out_valid / out_stall) gives exactly one transaction per
//   character: byte_valid with out_byte, out_last copied from the input and
//   the sticky decode_error after that character. Bytes of a segment whose
//   final transaction shows decode_error must be dropped by the consumer.
//   From input acceptance to out_valid the classifier first writes the
//   four-entry queue, then the decode stage loads the output register.
//   Throughput is one character per cycle while out_stall is low, set by
//   the single decode stage.
//   When the receiver stalls the output holds and the queue fills; in_stall
//   rises once four characters are waiting.
//   Reset clears the queue, the output valid and the group state, so the
//   first character starts a new group with no error.
// ----------------------------------------------------------------------------
module base64url_decoder_unit
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       byte_valid,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       decode_error
);

    queue_stat_t q_stat;
    logic        push;
    logic        pop;
    char_class_t push_data;
    char_class_t pop_data;

    // classify incoming characters
    b64d_front u_front
    (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_char   (in_char),
        .in_last   (in_last),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // decoupling queue
    b64d_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    // decode and output register
    b64d_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .pop_data     (pop_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_valid   (byte_valid),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .decode_error (decode_error)
    );

    // a byte is never delivered together with an error
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(byte_valid && decode_error))
        else $error("byte delivered with decode error");

    // no byte means a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> (out_byte == 8'h00))
        else $error("nonzero byte without byte_valid");

    // a full queue is never empty
    assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> q_stat.not_empty)
        else $error("queue status inconsistent");

    // the decode stage only takes from a queue that holds something
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_stat.not_empty)
        else $error("pop from empty queue");

endmodule

### verif/b64d_tb_pkg.sv
// ----------------------------------------------------------------------------
// b64d_tb_pkg
// Scoreboard for the base64url decoder: predicts one result per accepted
// character and compares each output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
package b64d_tb_pkg;

    import b64d_pkg::*;

    // one predicted output transaction
    typedef struct {
        logic       byte_valid;
        logic [7:0] data;
        logic       last;
        logic       error;
    } decoded_t;

    class decode_scoreboard;

        logic [1:0] group_pos;
        logic [5:0] prev_sextet;
        logic       error_flag;
        decoded_t   decoded_q[$];
        int         failures;
        int         chars_noted;
        int         bytes_seen;
        int         segments;
        int         bad_segments;

        function new();
            group_pos    = POS_FIRST;
            prev_sextet  = '0;
            error_flag   = 1'b0;
            failures     = 0;
            chars_noted  = 0;
            bytes_seen   = 0;
            segments     = 0;
            bad_segments = 0;
        endfunction

        // 6-bit value of an alphabet character, zero and 0 returned otherwise
        function bit sextet_of(input logic [7:0] ch, output logic [5:0] val);
            val = '0;
            if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z) begin
                val = 6'(ch - CHAR_UP_A);
                return 1'b1;
            end
            if (ch >= CHAR_LO_A && ch <= CHAR_LO_Z) begin
                val = 6'(ch - CHAR_LO_A + 8'(VAL_LO_BASE));
                return 1'b1;
            end
            if (ch >= CHAR_DIG_0 && ch <= CHAR_DIG_9) begin
                val = 6'(ch - CHAR_DIG_0 + 8'(VAL_DIG_BASE));
                return 1'b1;
            end
            if (ch == CHAR_MINUS) begin
                val = VAL_MINUS;
                return 1'b1;
            end
            if (ch == CHAR_UNDER) begin
                val = VAL_UNDER;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // predict the result of one accepted character
        function void note_char(input logic [7:0] ch, input logic last);
            logic [5:0] val;
            logic [7:0] data;
            logic       emit;
            decoded_t   d;
            val  = '0;
            data = '0;
            emit = 1'b0;
            if (ch == CHAR_PAD) begin
                // padding is only legal in the back half of a group
                if (group_pos == POS_FIRST || group_pos == POS_SECOND)
                    error_flag = 1'b1;
            end
            else if (!sextet_of(ch, val)) begin
                error_flag = 1'b1;
            end
            else begin
                emit = 1'b1;
                unique case (group_pos)
                    POS_SECOND: data = {prev_sextet, val[5:4]};
                    POS_THIRD:  data = {prev_sextet[3:0], val[5:2]};
                    POS_FOURTH: data = {prev_sextet[1:0], val};
                    default:    emit = 1'b0;
                endcase
            end
            // a lone character in the final group cannot form a byte
            if (last && group_pos == POS_FIRST)
                error_flag = 1'b1;
            if (error_flag) begin
                emit = 1'b0;
                data = '0;
            end
            d.byte_valid = emit;
            d.data       = data;
            d.last       = last;
            d.error      = error_flag;
            decoded_q    = {decoded_q, d};
            chars_noted++;
            // segment end starts the next group fresh
            if (last) begin
                segments++;
                if (error_flag)
                    bad_segments++;
                group_pos   = POS_FIRST;
                prev_sextet = '0;
                error_flag  = 1'b0;
            end
            else begin
                group_pos   = group_pos + 2'd1;
                prev_sextet = val;
            end
        endfunction

        function void compare(input string field, input logic [7:0] want,
                              input logic [7:0] got);
            if (got !== want) begin
                failures++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            end
        endfunction

        // check one accepted output transaction against the oldest prediction
        function void check_result(input logic bv, input logic [7:0] data,
                                   input logic last, input logic err);
            decoded_t d;
            if (decoded_q.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none actual %0b/%02h/%0b/%0b",
                         $time, bv, data, last, err);
                return;
            end
            d = decoded_q.pop_front();
            compare("byte_valid", 8'(d.byte_valid), 8'(bv));
            compare("out_byte", d.data, data);
            compare("out_last", 8'(d.last), 8'(last));
            compare("decode_error", 8'(d.error), 8'(err));
            if (bv === 1'b1)
                bytes_seen++;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

    endclass

endpackage

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for base64url_decoder_unit: a directed set of segments covering
// alphabet edges, padding, bad characters and length errors, then random
// segments, mostly well formed, with random idling on both channels and one
// long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;

    import b64d_pkg::*;
    import b64d_tb_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_item_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_char;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       out_last;
    logic       decode_error;

    char_item_t       char_q[$];
    logic [7:0]       seg_buf[$];
    bit               sending_done;
    decode_scoreboard sb;

    base64url_decoder_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_char      (in_char),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_valid   (byte_valid),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .decode_error (decode_error)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // move the collected segment into the character list, flag on the final one
    task automatic flush_segment();
        char_item_t item;
        for (int k = 0; k < seg_buf.size(); k++)
        begin
            item.ch   = seg_buf[k];
            item.last = (k == seg_buf.size() - 1);
            char_q    = {char_q, item};
        end
        seg_buf.delete();
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++)
            seg_buf = {seg_buf, s[k]};
        flush_segment();
    endtask

    // alphabet character for a 6-bit value
    function automatic logic [7:0] alpha_char(input logic [5:0] s);
        if (s < VAL_LO_BASE)
            return CHAR_UP_A + s;
        if (s < VAL_DIG_BASE)
            return CHAR_LO_A + (s - VAL_LO_BASE);
        if (s < VAL_MINUS)
            return CHAR_DIG_0 + (s - VAL_DIG_BASE);
        if (s == VAL_MINUS)
            return CHAR_MINUS;
        return CHAR_UNDER;
    endfunction

    // run control
    initial
    begin
        int kind;
        int len;
        int spot;
        rst_n = 1'b0;
        sb = new();

        // directed segments
        add_text("AZaz");
        add_text("09-_");
        add_text("QQ==");
        add_text("A=");
        add_text("=");
        add_text("QUI");
        seg_buf = {seg_buf, 8'hFF};
        seg_buf = {seg_buf, "B"};
        seg_buf = {seg_buf, "C"};
        flush_segment();
        add_text("Q");
        seg_buf = {seg_buf, 8'h00};
        seg_buf = {seg_buf, "A"};
        flush_segment();

        // random segments, mostly well formed
        while (char_q.size() < 774)
        begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 14);
            unique case (kind)
                6:
                begin
                    // full groups then a padded tail
                    len = 4 * $urandom_range(0, 3);
                    for (int k = 0; k < len; k++)
                        seg_buf = {seg_buf, alpha_char(6'($urandom_range(0, 63)))};
                    seg_buf = {seg_buf, alpha_char(6'($urandom_range(0, 63)))};
                    seg_buf = {seg_buf, alpha_char(6'($urandom_range(0, 63)))};
                    if ($urandom_range(0, 1))
                        seg_buf = {seg_buf, alpha_char(6'($urandom_range(0, 63)))};
                    else
                        seg_buf = {seg_buf, CHAR_PAD};
                    seg_buf = {seg_buf, CHAR_PAD};
                end
                7:
                begin
                    // noise: arbitrary bytes mixed into the text
                    for (int k = 0; k < len; k++)
                        if ($urandom_range(0, 3) == 0)
                            seg_buf = {seg_buf, 8'($urandom_range(0, 255))};
                        else
                            seg_buf = {seg_buf, alpha_char(6'($urandom_range(0, 63)))};
                end
                8:
                begin
                    // padding dropped at a random position
                    spot = $urandom_range(0, len - 1);
                    for (int k = 0; k < len; k++)
                        if (k == spot)
                            seg_buf = {seg_buf, CHAR_PAD};
                        else
                            seg_buf = {seg_buf, alpha_char(6'($urandom_range(0, 63)))};
                end
                9:
                begin
                    // lone character in the final group
                    len = 4 * $urandom_range(0, 3) + 1;
                    for (int k = 0; k < len; k++)
                        seg_buf = {seg_buf, alpha_char(6'($urandom_range(0, 63)))};
                end
                default:
                begin
                    // clean text, padding left implied
                    if (len % 4 == 1)
                        len++;
                    for (int k = 0; k < len; k++)
                        seg_buf = {seg_buf, alpha_char(6'($urandom_range(0, 63)))};
                end
            endcase
            flush_segment();
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (sending_done);
        // let the monitor note the final input transaction
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("checked %0d characters in %0d segments, %0d flagged bad, %0d bytes decoded",
                 sb.chars_noted, sb.segments, sb.bad_segments, sb.bytes_seen);
        $display("input and output idled at random, with one long output hold-off");
        if (sb.failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // character sender
    initial
    begin
        int  idx;
        bit  calm;
        idx = 0;
        in_valid <= 1'b0;
        in_char  <= '0;
        in_last  <= 1'b0;
        wait (rst_n === 1'b1);
        while (idx < char_q.size())
        begin
            @(posedge clk);
            if (in_valid && !in_stall)
                idx++;
            calm = (idx >= 300 && idx < 450);
            // a stalled transaction keeps its payload
            if (!(in_valid && in_stall))
            begin
                if (idx < char_q.size() && (calm || $urandom_range(0, 99) >= 30))
                begin
                    in_valid <= 1'b1;
                    in_char  <= char_q[idx].ch;
                    in_last  <= char_q[idx].last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
        sending_done = 1'b1;
    end

    // result receiver with one long hold-off
    initial
    begin
        int taken;
        int hold;
        bit held_once;
        taken     = 0;
        hold      = 0;
        held_once = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
                taken++;
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (!held_once && taken >= 120)
            begin
                held_once = 1'b1;
                hold      = 59;
                out_stall <= 1'b1;
            end
            else if (taken >= 400 && taken < 550)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 30);
        end
    end

    // transaction monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && !in_stall)
                sb.note_char(in_char, in_last);
            if (out_valid && !out_stall)
                sb.check_result(byte_valid, out_byte, out_last, decode_error);
        end
    end

    // run limit
    initial
    begin
        #720000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
rtl/core/b64d_pkg.sv
rtl/core/b64d_front.sv
rtl/core/b64d_queue.sv
rtl/core/b64d_back.sv
rtl/core/base64url_decoder_unit.sv
verif/b64d_tb_pkg.sv
verif/tb_top.sv
